/* hdl/rv32icd_pkg.sv */
// shared types and constants of the rv32i instruction control decoder
package rv32icd_pkg;

    // major opcodes, instruction bits 6..0
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    // alu operation codes
    localparam logic [3:0] ALU_ADD = 4'd1;
    localparam logic [3:0] ALU_SUB = 4'd2;
    localparam logic [3:0] ALU_AND = 4'd3;
    localparam logic [3:0] ALU_OR  = 4'd4;
    localparam logic [3:0] ALU_SLL = 4'd5;
    localparam logic [3:0] ALU_SLT = 4'd6;
    localparam logic [3:0] ALU_SRA = 4'd7;
    localparam logic [3:0] ALU_SRL = 4'd8;
    localparam logic [3:0] ALU_XOR = 4'd9;

    // funct3 codes of the alu group
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // operand 2 source
    localparam logic [1:0] OP2_REG  = 2'd0;
    localparam logic [1:0] OP2_IMMI = 2'd1;
    localparam logic [1:0] OP2_IMMS = 2'd2;

    // result source
    localparam logic [2:0] RES_PC4   = 3'd0;
    localparam logic [2:0] RES_IMMU  = 3'd1;
    localparam logic [2:0] RES_MEM   = 3'd2;
    localparam logic [2:0] RES_ALU   = 3'd3;
    localparam logic [2:0] RES_PCIMM = 3'd4;

    // next pc source
    localparam logic [1:0] NPC_ALU    = 2'd0;
    localparam logic [1:0] NPC_TARGET = 2'd1;
    localparam logic [1:0] NPC_PC4    = 2'd2;

    // branch kind
    localparam logic [1:0] BK_NONE = 2'd0;
    localparam logic [1:0] BK_COND = 2'd1;
    localparam logic [1:0] BK_JAL  = 2'd2;
    localparam logic [1:0] BK_JALR = 2'd3;

    localparam logic [2:0] SIZE_WORD = 3'd2;

    localparam int unsigned IN_WIDTH  = 64;
    localparam int unsigned OUT_WIDTH = 120;

    typedef struct packed {
        logic [3:0]  alu_op;
        logic [1:0]  op2_select;
        logic [2:0]  result_select;
        logic [1:0]  next_pc_select;
        logic        reg_write;
        logic        mem_write;
        logic [2:0]  access_size;
        logic [1:0]  branch_kind;
        logic        illegal;
        logic [31:0] operand_immediate;
        logic [31:0] branch_target;
        logic [31:0] upper_sum;
    } decode_t;

endpackage

/* hdl/rv32icd_decode.sv */
// combinational decode of one instruction word into control codes and immediates
module rv32icd_decode (
    input  logic [31:0]           instruction,
    input  logic [31:0]           fetch_address,
    output rv32icd_pkg::decode_t  decoded
);
    import rv32icd_pkg::*;

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_u;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic        use_j;
    logic [31:0] op_imm;

    function automatic logic [3:0] alu_for(input logic [2:0] f3, input logic [6:0] f7,
                                           input logic reg_form);
        logic [3:0] op;
        begin
            case (f3)
                F3_ADD:  op = (reg_form && (f7 != 7'd0)) ? ALU_SUB : ALU_ADD;
                F3_SLL:  op = ALU_SLL;
                F3_SLT:  op = ALU_SLT;
                F3_XOR:  op = ALU_XOR;
                F3_SR:   op = (f7 != 7'd0) ? ALU_SRA : ALU_SRL;
                F3_OR:   op = ALU_OR;
                F3_AND:  op = ALU_AND;
                default: op = ALU_ADD;
            endcase
            return op;
        end
    endfunction

    assign opcode = instruction[6:0];
    assign funct3 = instruction[14:12];
    assign funct7 = instruction[31:25];

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_u = {instruction[31:12], 12'd0};
    assign imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                    instruction[11:8], 1'b0};
    assign imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                    instruction[30:21], 1'b0};

    always_comb
    begin
        decoded                = '0;
        decoded.alu_op         = ALU_ADD;
        decoded.op2_select     = OP2_REG;
        decoded.result_select  = RES_PC4;
        decoded.next_pc_select = NPC_PC4;
        decoded.access_size    = SIZE_WORD;
        decoded.branch_kind    = BK_NONE;
        use_j                  = 1'b0;
        op_imm                 = 32'd0;
        case (opcode)
            OPC_OP:
            begin
                decoded.reg_write     = 1'b1;
                decoded.alu_op        = alu_for(funct3, funct7, 1'b1);
                decoded.result_select = RES_ALU;
            end
            OPC_OPIMM:
            begin
                decoded.reg_write     = 1'b1;
                decoded.alu_op        = alu_for(funct3, funct7, 1'b0);
                decoded.op2_select    = OP2_IMMI;
                decoded.result_select = RES_ALU;
                op_imm                = imm_i;
            end
            OPC_LOAD:
            begin
                decoded.reg_write     = 1'b1;
                decoded.op2_select    = OP2_IMMI;
                decoded.result_select = RES_MEM;
                decoded.access_size   = funct3;
                op_imm                = imm_i;
            end
            OPC_JALR:
            begin
                decoded.reg_write      = 1'b1;
                decoded.op2_select     = OP2_IMMI;
                decoded.result_select  = RES_ALU;
                decoded.next_pc_select = NPC_ALU;
                decoded.branch_kind    = BK_JALR;
                op_imm                 = imm_i;
            end
            OPC_STORE:
            begin
                decoded.mem_write   = 1'b1;
                decoded.op2_select  = OP2_IMMS;
                decoded.access_size = funct3;
                op_imm              = imm_s;
            end
            OPC_BRANCH:
            begin
                decoded.branch_kind = BK_COND;
                decoded.alu_op      = ALU_SUB;
            end
            OPC_LUI:
            begin
                decoded.reg_write     = 1'b1;
                decoded.result_select = RES_IMMU;
                op_imm                = imm_u;
            end
            OPC_AUIPC:
            begin
                decoded.reg_write     = 1'b1;
                decoded.result_select = RES_PCIMM;
                op_imm                = imm_u;
            end
            OPC_JAL:
            begin
                decoded.reg_write      = 1'b1;
                decoded.result_select  = RES_PC4;
                decoded.next_pc_select = NPC_TARGET;
                decoded.branch_kind    = BK_JAL;
                use_j                  = 1'b1;
            end
            default:
            begin
                decoded.illegal = 1'b1;
            end
        endcase

        // unknown opcode zeroes the immediate and both sums
        if (!decoded.illegal)
        begin
            decoded.operand_immediate = op_imm;
            decoded.branch_target     = fetch_address + (use_j ? imm_j : imm_b);
            decoded.upper_sum         = fetch_address + imm_u;
        end
    end

endmodule

/* hdl/rv32i_instruction_control_decoder.sv */
// top level of the rv32i instruction control decoder with input and result registers
//
// channel  | dir | fields (tdata, lowest bit up)
// ---------+-----+------------------------------------------------------------------
// s_axis   | in  | instruction[31:0], fetch_address[63:32]
// m_axis   | out | alu_op, op2_select, result_select, next_pc_select, reg_write,
//          |     | mem_write, access_size, branch_kind, illegal, operand_immediate,
//          |     | branch_target, upper_sum, zero pad to 120 bits
//
// one transfer in per cycle while not stalled; an item is held in the input register, then
// in the result register (decode and the two pc adds sit between the registers)
// both registers advance whenever the result register is empty or being taken,
// so a stall on m_tready backs up into s_tready without losing or repeating a transfer
// rst_n clears only the valid flags; payload registers carry no reset
module rv32i_instruction_control_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // instruction[31:0], fetch_address[63:32]
    input  logic [rv32icd_pkg::IN_WIDTH-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // alu_op[3:0], op2_select[5:4], result_select[8:6], next_pc_select[10:9],
    // reg_write[11], mem_write[12], access_size[15:13], branch_kind[17:16],
    // illegal[18], operand_immediate[50:19], branch_target[82:51],
    // upper_sum[114:83], zero[119:115]
    output logic [rv32icd_pkg::OUT_WIDTH-1:0]   m_tdata
);
    import rv32icd_pkg::*;

    logic        in_valid_reg;
    logic [31:0] instr_reg;
    logic [31:0] pc_reg;
    logic        out_valid_reg;
    decode_t     result_reg;
    decode_t     decoded;
    logic        advance;

    // result register can load when it is empty or its transfer completes now
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            instr_reg <= s_tdata[31:0];
            pc_reg    <= s_tdata[63:32];
        end
    end

    rv32icd_decode u_decode (
        .instruction   (instr_reg),
        .fetch_address (pc_reg),
        .decoded       (decoded)
    );

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       result_reg.upper_sum,
                       result_reg.branch_target,
                       result_reg.operand_immediate,
                       result_reg.illegal,
                       result_reg.branch_kind,
                       result_reg.access_size,
                       result_reg.mem_write,
                       result_reg.reg_write,
                       result_reg.next_pc_select,
                       result_reg.result_select,
                       result_reg.op2_select,
                       result_reg.alu_op};

endmodule

/* sim/decode_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the rv32i control decoder: predicts each decode and compares results
module decode_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rv32icd_pkg::IN_WIDTH-1:0]  s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rv32icd_pkg::OUT_WIDTH-1:0] m_tdata,
    output int                                mismatch_count,
    output int                                outstanding
);
    import rv32icd_pkg::*;

    decode_t expected_decodes[$];
    decode_t seen;
    decode_t want;
    int      result_index;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
        result_index   = 0;
    end

    function automatic logic [3:0] alu_code_for(logic [2:0] f3, logic [6:0] f7, logic reg_form);
        case (f3)
            F3_ADD:  return (reg_form && f7 != 7'd0) ? ALU_SUB : ALU_ADD;
            F3_SLL:  return ALU_SLL;
            F3_SLT:  return ALU_SLT;
            F3_XOR:  return ALU_XOR;
            F3_SR:   return (f7 != 7'd0) ? ALU_SRA : ALU_SRL;
            F3_OR:   return ALU_OR;
            F3_AND:  return ALU_AND;
            default: return ALU_ADD;
        endcase
    endfunction

    function automatic decode_t decode_predict(logic [31:0] insn, logic [31:0] pc);
        decode_t     d;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_u;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic        use_jal;
        imm_i = {{20{insn[31]}}, insn[31:20]};
        imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
        imm_u = {insn[31:12], 12'b0};
        imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
        imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
        use_jal = 1'b0;
        d = '0;
        d.alu_op         = ALU_ADD;
        d.op2_select     = OP2_REG;
        d.result_select  = RES_PC4;
        d.next_pc_select = NPC_PC4;
        d.access_size    = SIZE_WORD;
        d.branch_kind    = BK_NONE;
        case (insn[6:0])
            OPC_OP:
            begin
                d.reg_write     = 1'b1;
                d.alu_op        = alu_code_for(insn[14:12], insn[31:25], 1'b1);
                d.result_select = RES_ALU;
            end
            OPC_OPIMM:
            begin
                d.reg_write         = 1'b1;
                d.alu_op            = alu_code_for(insn[14:12], insn[31:25], 1'b0);
                d.op2_select        = OP2_IMMI;
                d.result_select     = RES_ALU;
                d.operand_immediate = imm_i;
            end
            OPC_LOAD:
            begin
                d.reg_write         = 1'b1;
                d.op2_select        = OP2_IMMI;
                d.result_select     = RES_MEM;
                d.access_size       = insn[14:12];
                d.operand_immediate = imm_i;
            end
            OPC_JALR:
            begin
                d.reg_write         = 1'b1;
                d.op2_select        = OP2_IMMI;
                d.result_select     = RES_ALU;
                d.next_pc_select    = NPC_ALU;
                d.branch_kind       = BK_JALR;
                d.operand_immediate = imm_i;
            end
            OPC_STORE:
            begin
                d.mem_write         = 1'b1;
                d.op2_select        = OP2_IMMS;
                d.access_size       = insn[14:12];
                d.operand_immediate = imm_s;
            end
            OPC_BRANCH:
            begin
                // next pc stays pc+4, the branch unit resolves later
                d.branch_kind = BK_COND;
                d.alu_op      = ALU_SUB;
            end
            OPC_LUI:
            begin
                d.reg_write         = 1'b1;
                d.result_select     = RES_IMMU;
                d.operand_immediate = imm_u;
            end
            OPC_AUIPC:
            begin
                d.reg_write         = 1'b1;
                d.result_select     = RES_PCIMM;
                d.operand_immediate = imm_u;
            end
            OPC_JAL:
            begin
                d.reg_write      = 1'b1;
                d.result_select  = RES_PC4;
                d.next_pc_select = NPC_TARGET;
                d.branch_kind    = BK_JAL;
                use_jal          = 1'b1;
            end
            default:
                d.illegal = 1'b1;
        endcase
        // unknown opcode leaves all three data words at zero
        if (!d.illegal)
        begin
            d.branch_target = pc + (use_jal ? imm_j : imm_b);
            d.upper_sum     = pc + imm_u;
        end
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        $display("checker: %s", msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string field, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      result_index, field, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_decodes.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.alu_op            = m_tdata[3:0];
                seen.op2_select        = m_tdata[5:4];
                seen.result_select     = m_tdata[8:6];
                seen.next_pc_select    = m_tdata[10:9];
                seen.reg_write         = m_tdata[11];
                seen.mem_write         = m_tdata[12];
                seen.access_size       = m_tdata[15:13];
                seen.branch_kind       = m_tdata[17:16];
                seen.illegal           = m_tdata[18];
                seen.operand_immediate = m_tdata[50:19];
                seen.branch_target     = m_tdata[82:51];
                seen.upper_sum         = m_tdata[114:83];
                if (expected_decodes.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_index));
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    compare_field("alu_op", 32'(seen.alu_op), 32'(want.alu_op));
                    compare_field("op2_select", 32'(seen.op2_select),
                                  32'(want.op2_select));
                    compare_field("result_select", 32'(seen.result_select),
                                  32'(want.result_select));
                    compare_field("next_pc_select", 32'(seen.next_pc_select),
                                  32'(want.next_pc_select));
                    compare_field("reg_write", 32'(seen.reg_write), 32'(want.reg_write));
                    compare_field("mem_write", 32'(seen.mem_write), 32'(want.mem_write));
                    compare_field("access_size", 32'(seen.access_size),
                                  32'(want.access_size));
                    compare_field("branch_kind", 32'(seen.branch_kind),
                                  32'(want.branch_kind));
                    compare_field("illegal", 32'(seen.illegal), 32'(want.illegal));
                    compare_field("operand_immediate", seen.operand_immediate,
                                  want.operand_immediate);
                    compare_field("branch_target", seen.branch_target, want.branch_target);
                    compare_field("upper_sum", seen.upper_sum, want.upper_sum);
                end
                result_index++;
            end
            if (s_tvalid && s_tready)
                expected_decodes.insert(expected_decodes.size(),
                                        decode_predict(s_tdata[31:0], s_tdata[63:32]));
        end
        outstanding = expected_decodes.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// top of the decoder testbench: clock, reset, instruction stimulus, result stalls, verdict
module testbench;
    import rv32icd_pkg::*;

    // worst correct run is about 1530 transfers
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // instruction[31:0], fetch_address[63:32]
    logic [IN_WIDTH-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // alu_op .. upper_sum from bit 0 up, zero pad at the top
    logic [OUT_WIDTH-1:0] m_tdata;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;

    // receiver stall pattern: mode is redrawn at random, paced by stall_phase
    int   stall_mode = 0;
    int   stall_phase = 0;

    logic [6:0] legal_opcodes[9] = '{OPC_OP, OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_STORE,
                                     OPC_BRANCH, OPC_LUI, OPC_AUIPC, OPC_JAL};

    // free-running clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rv32i_instruction_control_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    decode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side back-pressure: always ready, coin flip, mostly stalled, or alternating
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 63)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_phase[0];
        endcase
    end

    // present one instruction and hold it until the transfer; returns just after that edge
    // s_tready is looked at on the falling edge, where it is settled for the coming edge
    task automatic send_insn(logic [31:0] insn, logic [31:0] pc);
        s_tvalid <= 1'b1;
        s_tdata  <= {pc, insn};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // drop valid and let the decoder run dry
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // random word, mostly with a legal opcode so every decode path sees random content
    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < 85)
        begin
            w[6:0] = legal_opcodes[$urandom_range(0, 8)];
            // keep the usual funct7 values common so add/sub and srl/sra both show up
            if (w[6:0] inside {OPC_OP, OPC_OPIMM} && $urandom_range(0, 1))
                w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
        end
        return w;
    endfunction

    function automatic logic [31:0] random_pc();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            1:       return $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        int          burst_len;
        int          gap;
        int          sent;
        bit          paused;

        paused = 1'b0;

        // register group: every funct3 with funct7 clear
        for (int f3 = 0; f3 < 8; f3++)
            directed.insert(directed.size(),
                            {32'h0000_1000, 7'h00, 5'd5, 5'd6, 3'(f3), 5'd7, OPC_OP});
        // sub, sra with an odd nonzero funct7, sltu with funct7 set stays add
        directed.insert(directed.size(),
                        {32'h0000_2000, 7'h20, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP});
        directed.insert(directed.size(),
                        {32'h0000_2004, 7'h7F, 5'd31, 5'd31, F3_SR, 5'd31, OPC_OP});
        directed.insert(directed.size(),
                        {32'h0000_2008, 7'h20, 5'd1, 5'd2, 3'd3, 5'd3, OPC_OP});
        // immediate group: all-ones imm must stay add, srai, sltiu with max positive imm
        directed.insert(directed.size(),
                        {32'hFFFF_FFFF, 12'hFFF, 5'd1, F3_ADD, 5'd2, OPC_OPIMM});
        directed.insert(directed.size(),
                        {32'h0000_0000, 7'h20, 5'd3, 5'd1, F3_SR, 5'd2, OPC_OPIMM});
        directed.insert(directed.size(),
                        {32'h1234_5678, 12'h7FF, 5'd4, 3'd3, 5'd5, OPC_OPIMM});
        // load with the widest funct3 and most negative offset
        directed.insert(directed.size(),
                        {32'h8000_0000, 12'h800, 5'd31, 3'd7, 5'd31, OPC_LOAD});
        // stores: negative offset, unusual size
        directed.insert(directed.size(),
                        {32'h7FFF_FFFF, 7'h7F, 5'd0, 5'd0, 3'd5, 5'h1F, OPC_STORE});
        directed.insert(directed.size(),
                        {32'h0000_0010, 7'h00, 5'd9, 5'd8, 3'd2, 5'h00, OPC_STORE});
        // conditional branches: backward from zero and forward past the top, both wrap
        directed.insert(directed.size(),
                        {32'h0000_0000, 7'h7F, 5'd1, 5'd2, 3'd1, 5'h1F, OPC_BRANCH});
        directed.insert(directed.size(),
                        {32'hFFFF_FFFC, 7'h3F, 5'd1, 5'd2, 3'd0, 5'h1E, OPC_BRANCH});
        // upper immediates at the extremes
        directed.insert(directed.size(), {32'h0000_1000, 20'hFFFFF, 5'd1, OPC_LUI});
        directed.insert(directed.size(), {32'h8000_0000, 20'h80000, 5'd1, OPC_AUIPC});
        // jal furthest back from zero and furthest forward from the top
        directed.insert(directed.size(), {32'h0000_0000, 20'h80000, 5'd1, OPC_JAL});
        directed.insert(directed.size(), {32'hFFFF_FFFF, 20'h7FFFF, 5'd1, OPC_JAL});
        directed.insert(directed.size(),
                        {32'h0000_4000, 12'h800, 5'd1, 3'd0, 5'd1, OPC_JALR});
        // unknown opcodes: all zeros, all ones, one bit away from the register group
        directed.insert(directed.size(), {32'hDEAD_BEEF, 32'h0000_0000});
        directed.insert(directed.size(), {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        directed.insert(directed.size(), {32'h0000_0100, 25'h1FF_FFFF, 7'b0110010});

        // hold reset, then release on a rising edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part back to back
        foreach (directed[i])
            send_insn(directed[i][31:0], directed[i][63:32]);
        drain_results();

        // random part in bursts; a quarter of bursts run with no gap after them
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 24);
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++)
            begin
                send_insn(random_insn(), random_pc());
                sent++;
            end
            // one full stop midway, waiting for every outstanding result
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // let the pipeline empty, then keep clocking for anything stray
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
